// ----- design/rabs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rabs_pkg
// Shared types, constants and tables for the running-average background
// subtraction unit.
// ----------------------------------------------------------------------------
package rabs_pkg;

  localparam int MAX_PIXELS = 524288;
  localparam int ADDR_W     = $clog2(MAX_PIXELS);
  localparam int IDX_W      = $clog2(MAX_PIXELS + 1);

  localparam int FRAME_W    = 11;
  localparam logic [FRAME_W-1:0] FRAME_MAX = '1;
  localparam int K_W        = 11;

  localparam int HUE_W      = 15;
  localparam int SV_W       = 13;
  localparam logic [15:0] HUE_FULL = 16'd23040;

  // HSV division by reciprocal: N < 2^21, divisor < 2^9, shift 30
  localparam int HSV_SHIFT   = 30;
  localparam int HSV_RECIP_W = 30;
  localparam int HSV_N_W     = 21;
  localparam int HSV_P_W     = HSV_N_W + HSV_RECIP_W;
  localparam logic [HSV_RECIP_W-1:0] VAL_RECIP =
    HSV_RECIP_W'(((64'd1 << HSV_SHIFT) + 64'd509) / 64'd510);

  // average update: N < 2^16, divisor 2k < 2^12, shift 28
  localparam int MV_SHIFT   = 28;
  localparam int MV_RECIP_W = 28;
  localparam int MV_N_W     = 16;
  localparam int MV_P_W     = MV_N_W + MV_RECIP_W;

  typedef enum logic [1:0] {
    REG_HISTORY = 2'd0,
    REG_HUE_THR = 2'd1,
    REG_SAT_THR = 2'd2,
    REG_VAL_THR = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [10:0] history_frames;
    logic [8:0]  hue_threshold;
    logic [12:0] sat_threshold;
    logic [12:0] val_threshold;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_in_frame;
  } pixel_t;

  typedef struct packed {
    logic background;
    logic frame_done;
    logic overflow;
  } result_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SV_W-1:0]  sat;
    logic [SV_W-1:0]  val;
  } hsv_t;

  typedef struct packed {
    logic              last;
    logic              ovf;
    logic              first;
    logic [ADDR_W-1:0] addr;
    logic [K_W-1:0]    k;
  } tag_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    tag_t       tag;
  } front_t;

  typedef struct packed {
    tag_t                  tag;
    logic [MV_RECIP_W-1:0] recip;
  } carry_t;

  typedef struct packed {
    carry_t c;
    hsv_t   cur;
  } item_t;

  typedef logic [255:0][HSV_RECIP_W-1:0] recip_tab_t;

  // ceil(2^29 / i): divides by 2*i with a shift of 30
  function automatic recip_tab_t build_recip();
    recip_tab_t tab;
    tab[0] = '0;
    for (int i = 1; i < 256; i++) begin
      tab[i] = HSV_RECIP_W'(((64'd1 << (HSV_SHIFT - 1)) + 64'(i) - 64'd1) / 64'(i));
    end
    return tab;
  endfunction

  localparam recip_tab_t RECIP_TAB = build_recip();

endpackage

// ----- design/rabs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rabs_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rabs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first on a clash
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ----- design/rabs_recip.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rabs_recip
// Pipelined restoring divider giving ceil(2^27 / k), one quotient bit per
// stage, with the transaction carried alongside.
// ----------------------------------------------------------------------------
module rabs_recip (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  rabs_pkg::front_t                in_front,
  output logic                            out_valid,
  output rabs_pkg::front_t                out_front,
  output logic [rabs_pkg::MV_RECIP_W-1:0] out_recip
);
  import rabs_pkg::*;

  localparam int ST = MV_RECIP_W;

  logic [ST-1:0]         v;
  front_t                f        [ST];
  logic [K_W-1:0]        rem      [ST];
  logic [ST-1:0]         q        [ST];
  front_t                f_next   [ST];
  logic [K_W-1:0]        rem_next [ST];
  logic [ST-1:0]         q_next   [ST];

  always_comb begin
    front_t         fi;
    logic [K_W-1:0] ri;
    logic [ST-1:0]  qi;
    logic [ST-1:0]  num;
    logic [K_W:0]   sh;
    logic           ge;
    for (int s = 0; s < ST; s++) begin
      if (s == 0) begin
        fi = in_front;
        ri = '0;
        qi = '0;
      end else begin
        fi = f[s-1];
        ri = rem[s-1];
        qi = q[s-1];
      end
      // numerator 2^27 + k - 1 gives the ceiling
      num = (ST'(1) << (ST - 1)) + ST'(fi.tag.k) - ST'(1);
      sh  = {ri, num[ST-1-s]};
      ge  = sh >= {1'b0, fi.tag.k};
      f_next[s]   = fi;
      q_next[s]   = {qi[ST-2:0], ge};
      rem_next[s] = ge ? K_W'(sh - {1'b0, fi.tag.k}) : sh[K_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[ST-2:0], in_valid};
    end
    if (en) begin
      for (int s = 0; s < ST; s++) begin
        f[s]   <= f_next[s];
        q[s]   <= q_next[s];
        rem[s] <= rem_next[s];
      end
    end
  end

  assign out_valid = v[ST-1];
  assign out_front = f[ST-1];
  assign out_recip = q[ST-1];

endmodule

// ----- design/rabs_hsv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rabs_hsv
// Four-stage RGB to HSV converter; divisions by reciprocal table and
// multiply, exact for the operand ranges used.
// ----------------------------------------------------------------------------
module rabs_hsv (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  rabs_pkg::front_t                in_front,
  input  logic [rabs_pkg::MV_RECIP_W-1:0] in_recip,
  output logic                            out_valid,
  output rabs_pkg::item_t                 out_item
);
  import rabs_pkg::*;

  // stage 1
  logic               s1_v;
  carry_t             s1_c;
  logic [7:0]         s1_d;
  logic [7:0]         s1_mx;
  logic signed [22:0] s1_t;
  logic [15:0]        s1_base;
  // stage 2
  logic               s2_v;
  carry_t             s2_c;
  logic               s2_neg;
  logic               s2_dz;
  logic [15:0]        s2_base;
  logic [HSV_N_W-1:0] s2_nh, s2_ns, s2_nv;
  logic [HSV_RECIP_W-1:0] s2_md, s2_mm;
  // stage 3
  logic               s3_v;
  carry_t             s3_c;
  logic               s3_neg;
  logic               s3_dz;
  logic [15:0]        s3_base;
  logic [12:0]        s3_qh;
  logic [SV_W-1:0]    s3_qs, s3_qv;

  logic [7:0]         mx, mn, d;
  logic signed [8:0]  diff;
  logic [15:0]        base;
  logic signed [22:0] t;
  logic signed [22:0] tn;
  logic [HSV_P_W-1:0] ph, ps, pv;
  logic [15:0]        h_raw, h_wrap;

  always_comb begin
    logic [7:0] r, g, b;
    r  = in_front.red;
    g  = in_front.green;
    b  = in_front.blue;
    mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
    mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
    d  = mx - mn;
    // red wins a shared maximum, then green
    if (mx == r) begin
      diff = $signed({1'b0, g}) - $signed({1'b0, b});
      base = 16'd23040;
    end else if (mx == g) begin
      diff = $signed({1'b0, b}) - $signed({1'b0, r});
      base = 16'd7680;
    end else begin
      diff = $signed({1'b0, r}) - $signed({1'b0, g});
      base = 16'd15360;
    end
    t = 23'(diff) * 23'sd7680 + $signed({15'd0, d});
  end

  assign tn = -s1_t;

  assign ph = HSV_P_W'(s2_nh) * HSV_P_W'(s2_md);
  assign ps = HSV_P_W'(s2_ns) * HSV_P_W'(s2_mm);
  assign pv = HSV_P_W'(s2_nv) * HSV_P_W'(VAL_RECIP);

  assign h_raw  = s3_neg ? s3_base - 16'(s3_qh) : s3_base + 16'(s3_qh);
  assign h_wrap = (h_raw >= HUE_FULL) ? h_raw - HUE_FULL : h_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_v      <= in_valid;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      out_valid <= s3_v;
    end
    if (en) begin
      s1_c    <= '{tag: in_front.tag, recip: in_recip};
      s1_d    <= d;
      s1_mx   <= mx;
      s1_t    <= t;
      s1_base <= base;

      // negative hue offset: floor by rounding the magnitude up
      s2_c    <= s1_c;
      s2_neg  <= s1_t[22];
      s2_dz   <= s1_d == 8'd0;
      s2_base <= s1_base;
      s2_nh   <= s1_t[22] ? HSV_N_W'(tn + $signed({14'd0, s1_d, 1'b0}) - 23'sd1)
                          : HSV_N_W'(s1_t);
      s2_ns   <= HSV_N_W'({s1_d, 13'd0}) + HSV_N_W'(s1_mx);
      s2_nv   <= HSV_N_W'({s1_mx, 13'd0}) + HSV_N_W'(255);
      s2_md   <= RECIP_TAB[s1_d];
      s2_mm   <= RECIP_TAB[s1_mx];

      s3_c    <= s2_c;
      s3_neg  <= s2_neg;
      s3_dz   <= s2_dz;
      s3_base <= s2_base;
      s3_qh   <= ph[HSV_SHIFT+12:HSV_SHIFT];
      s3_qs   <= ps[HSV_SHIFT+SV_W-1:HSV_SHIFT];
      s3_qv   <= pv[HSV_SHIFT+SV_W-1:HSV_SHIFT];

      out_item.c       <= s3_c;
      out_item.cur.hue <= s3_dz ? '0 : h_wrap[HUE_W-1:0];
      out_item.cur.sat <= s3_qs;
      out_item.cur.val <= s3_qv;
    end
  end

endmodule

// ----- design/rabs_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rabs_update
// Average store read-modify-write: read, compare and scale, write back,
// with write forwarding and an interlock on back-to-back use of
// the same entry. Holds the result register.
// ----------------------------------------------------------------------------
module rabs_update (
  input  logic              clk,
  input  logic              rst,
  input  rabs_pkg::cfg_t    cfg,
  input  logic              r_valid,
  input  rabs_pkg::item_t   r_item,
  output logic              take,
  output logic              result_valid,
  input  logic              result_stall,
  output rabs_pkg::result_t result
);
  import rabs_pkg::*;

  function automatic logic [HUE_W-1:0] absd(input logic [HUE_W-1:0] a,
                                            input logic [HUE_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // round(mag / k) as floor((2*mag + k) / 2k) by reciprocal
  function automatic logic [HUE_W-1:0] scale(input logic [HUE_W-1:0]      mag,
                                             input logic [K_W-1:0]        k,
                                             input logic [MV_RECIP_W-1:0] m);
    logic [MV_N_W-1:0] n;
    logic [MV_P_W-1:0] p;
    n = MV_N_W'({mag, 1'b0}) + MV_N_W'(k);
    p = MV_P_W'(n) * MV_P_W'(m);
    return p[MV_SHIFT+HUE_W-1:MV_SHIFT];
  endfunction

  logic        en, hazard, we;
  hsv_t        rdata, fwd_data, stored, avg, upd;

  logic        fwd_hit;
  logic        m1_valid;
  item_t       m1;

  logic        m2_valid;
  hsv_t        m2_avg;
  logic [2:0]  m2_up;
  logic [HUE_W-1:0] m2_qh, m2_qs, m2_qv;
  logic        m2_bg, m2_last, m2_ovf;
  logic [ADDR_W-1:0] m2_addr;

  logic [HUE_W-1:0] dh, ds, dv;
  logic        bg;

  assign en     = !(result_valid && result_stall);
  assign hazard = r_valid && !r_item.c.tag.ovf && m1_valid && !m1.c.tag.ovf &&
                  (r_item.c.tag.addr == m1.c.tag.addr);
  assign take   = en && !hazard;
  assign we     = en && m2_valid && !m2_ovf;

  rabs_ram #(
    .WIDTH($bits(hsv_t)),
    .DEPTH(MAX_PIXELS)
  ) u_store (
    .clk  (clk),
    .re   (en),
    .raddr(r_item.c.tag.addr),
    .rdata(rdata),
    .we   (we),
    .waddr(m2_addr),
    .wdata(upd)
  );

  always_comb begin
    stored = fwd_hit ? fwd_data : rdata;
    avg    = m1.c.tag.first ? m1.cur : stored;
    dh     = absd(m1.cur.hue, avg.hue);
    ds     = absd(HUE_W'(m1.cur.sat), HUE_W'(avg.sat));
    dv     = absd(HUE_W'(m1.cur.val), HUE_W'(avg.val));
    bg     = !m1.c.tag.ovf &&
             (dh <= {cfg.hue_threshold, 6'd0}) &&
             (ds <= HUE_W'(cfg.sat_threshold)) &&
             (dv <= HUE_W'(cfg.val_threshold));
  end

  always_comb begin
    upd.hue = m2_up[2] ? m2_avg.hue + m2_qh : m2_avg.hue - m2_qh;
    upd.sat = m2_up[1] ? m2_avg.sat + m2_qs[SV_W-1:0] : m2_avg.sat - m2_qs[SV_W-1:0];
    upd.val = m2_up[0] ? m2_avg.val + m2_qv[SV_W-1:0] : m2_avg.val - m2_qv[SV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit      <= 1'b0;
      m1_valid     <= 1'b0;
      m2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      // write landing on the entry being read this edge
      fwd_hit      <= we && (m2_addr == r_item.c.tag.addr);
      m1_valid     <= r_valid && !hazard;
      m2_valid     <= m1_valid;
      result_valid <= m2_valid;
    end
    if (en) begin
      fwd_data <= upd;
      m1       <= r_item;
      m2_avg   <= avg;
      m2_up    <= {m1.cur.hue >= avg.hue, m1.cur.sat >= avg.sat, m1.cur.val >= avg.val};
      m2_qh    <= scale(dh, m1.c.tag.k, m1.c.recip);
      m2_qs    <= scale(ds, m1.c.tag.k, m1.c.recip);
      m2_qv    <= scale(dv, m1.c.tag.k, m1.c.recip);
      m2_bg    <= bg;
      m2_last  <= m1.c.tag.last;
      m2_ovf   <= m1.c.tag.ovf;
      m2_addr  <= m1.c.tag.addr;
      result   <= '{background: m2_bg, frame_done: m2_last, overflow: m2_ovf};
    end
  end

endmodule

// ----- design/running_average_background_subtract_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_average_background_subtract_unit
// Per-pixel HSV running average with background/foreground decision.
//
//   channel  direction  handshake               payload
//   pixel    in         pixel_valid/stall       rabs_pkg::pixel_t
//   result   out        result_valid/stall      rabs_pkg::result_t
//   cfg      in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One pixel per clock unless stalled; each pixel passes the 28-stage
// reciprocal divider for k, 4 HSV stages, then read, scale and write.
// When the same store entry is needed by two consecutive pixels (frames of
// one pixel) one bubble is inserted at the store read port.
// Reset is synchronous; the average store has no clearing pass.
// A stalled result freezes the whole pipe and stalls the pixel input.
// ----------------------------------------------------------------------------
module running_average_background_subtract_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              pixel_valid,
  output logic              pixel_stall,
  input  rabs_pkg::pixel_t  pixel,
  output logic              result_valid,
  input  logic              result_stall,
  output rabs_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [12:0]       cfg_data
);
  import rabs_pkg::*;

  cfg_t               cfg;
  logic [FRAME_W-1:0] frame_count;
  logic [IDX_W-1:0]   pixel_index;
  logic               take, acc, ovf;
  logic [K_W-1:0]     hist_eff, k;
  logic [FRAME_W:0]   fc1;
  front_t             front;

  logic               rc_valid;
  front_t             rc_front;
  logic [MV_RECIP_W-1:0] rc_recip;
  logic               hv_valid;
  item_t              hv_item;

  assign cfg_ready   = 1'b1;
  assign pixel_stall = !take;
  assign acc         = pixel_valid && take;
  assign ovf         = pixel_index >= IDX_W'(MAX_PIXELS);

  assign hist_eff = (cfg.history_frames == '0) ? K_W'(1) : cfg.history_frames;
  assign fc1      = {1'b0, frame_count} + 1'b1;
  assign k        = (fc1 < {1'b0, hist_eff}) ? fc1[K_W-1:0] : hist_eff;

  always_comb begin
    front.red       = pixel.red;
    front.green     = pixel.green;
    front.blue      = pixel.blue;
    front.tag.last  = pixel.last_in_frame;
    front.tag.ovf   = ovf;
    front.tag.first = frame_count == '0;
    front.tag.addr  = pixel_index[ADDR_W-1:0];
    front.tag.k     = k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.history_frames <= 11'd30;
      cfg.hue_threshold  <= 9'd10;
      cfg.sat_threshold  <= 13'd410;
      cfg.val_threshold  <= 13'd410;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_HISTORY: cfg.history_frames <= cfg_data[10:0];
        REG_HUE_THR: cfg.hue_threshold  <= cfg_data[8:0];
        REG_SAT_THR: cfg.sat_threshold  <= cfg_data;
        REG_VAL_THR: cfg.val_threshold  <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      pixel_index <= '0;
    end else if (acc) begin
      if (pixel.last_in_frame) begin
        pixel_index <= '0;
        if (frame_count != FRAME_MAX) begin
          frame_count <= frame_count + 1'b1;
        end
      end else if (!ovf) begin
        pixel_index <= pixel_index + 1'b1;
      end
    end
  end

  rabs_recip u_recip (
    .clk      (clk),
    .rst      (rst),
    .en       (take),
    .in_valid (acc),
    .in_front (front),
    .out_valid(rc_valid),
    .out_front(rc_front),
    .out_recip(rc_recip)
  );

  rabs_hsv u_hsv (
    .clk      (clk),
    .rst      (rst),
    .en       (take),
    .in_valid (rc_valid),
    .in_front (rc_front),
    .in_recip (rc_recip),
    .out_valid(hv_valid),
    .out_item (hv_item)
  );

  rabs_update u_update (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .r_valid     (hv_valid),
    .r_item      (hv_item),
    .take        (take),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

// ----- sim/tb_running_average_background_subtract_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_running_average_background_subtract_unit
// Self-checking bench for the running-average background subtraction unit.
// Frame zero loads the per-pixel average from a fixed base picture. Later
// frames are mostly noisy copies of that picture, so both background and
// foreground decisions occur. Frames are never longer than frame zero, so
// no unwritten average entry is ever read. Registers are rewritten between
// phases, with the extremes included. Every accepted pixel is run through a
// local HSV/average predictor, and each result transaction is checked
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_running_average_background_subtract_unit;
  import rabs_pkg::*;

  localparam int BASE_LEN   = 20;
  localparam int WDOG_LIMIT = 4000;
  localparam int DRAIN      = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        pixel_valid = 1'b0;
  logic        pixel_stall;
  pixel_t      pixel = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  reg_idx_t    cfg_index = REG_HISTORY;
  logic [12:0] cfg_data = '0;

  running_average_background_subtract_unit uut (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // predictor state
  hsv_t        avg_store [int];
  int unsigned frame_cnt = 0;
  int unsigned pix_idx = 0;
  int unsigned hist_len = 30;
  int unsigned hue_thr = 10;
  int unsigned sat_thr = 410;
  int unsigned val_thr = 410;

  pixel_t  pending_px [$];
  result_t expected_res [$];
  pixel_t  base_pic [BASE_LEN];

  int  errors = 0;
  int  gap = 0;
  int  stall_left = 0;
  int  long_req = 0;
  int  long_done = 0;
  bit  idle_on = 1'b0;
  int  quiet = 0;

  function automatic hsv_t rgb_to_hsv(int r, int g, int b);
    int   mx, mn, d, diff, hbase, num, q;
    hsv_t o;
    mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
    mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
    d  = mx - mn;
    o  = '0;
    if (d != 0) begin
      if (mx == r) begin
        diff = g - b; hbase = 360;
      end else if (mx == g) begin
        diff = b - r; hbase = 120;
      end else begin
        diff = r - g; hbase = 240;
      end
      num = hbase * 64 * d + 3840 * diff;
      q = (2 * num + d) / (2 * d);
      while (q >= int'(HUE_FULL)) q -= int'(HUE_FULL);
      o.hue = q;
    end
    o.sat = (mx == 0) ? 0 : (8192 * d + mx) / (2 * mx);
    o.val = (8192 * mx + 255) / 510;
    return o;
  endfunction

  function automatic int step_avg(int avg, int cur, int k);
    int mag, q;
    mag = (avg > cur) ? avg - cur : cur - avg;
    q = (2 * mag + k) / (2 * k);
    return (cur >= avg) ? avg + q : avg - q;
  endfunction

  function automatic int adiff(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void predict_pixel(pixel_t p);
    result_t r;
    hsv_t    cur, e;
    int      k;
    r = '0;
    r.frame_done = p.last_in_frame;
    cur = rgb_to_hsv(p.red, p.green, p.blue);
    if (pix_idx >= MAX_PIXELS) begin
      r.overflow = 1'b1;
    end else begin
      k = (hist_len == 0) ? 1 : hist_len;
      if (frame_cnt + 1 < k) k = frame_cnt + 1;
      if (frame_cnt == 0) avg_store[pix_idx] = cur;
      e = avg_store[pix_idx];
      r.background = adiff(cur.hue, e.hue) <= hue_thr * 64 &&
                     adiff(cur.sat, e.sat) <= sat_thr &&
                     adiff(cur.val, e.val) <= val_thr;
      e.hue = step_avg(e.hue, cur.hue, k);
      e.sat = step_avg(e.sat, cur.sat, k);
      e.val = step_avg(e.val, cur.val, k);
      avg_store[pix_idx] = e;
      pix_idx++;
    end
    if (p.last_in_frame) begin
      pix_idx = 0;
      if (frame_cnt < 2047) frame_cnt++;
    end
    expected_res.push_back(r);
  endfunction

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
      gap <= 0;
    end else begin
      if (pixel_valid && !pixel_stall) predict_pixel(pixel);
      if (!(pixel_valid && pixel_stall)) begin
        if (gap > 0) begin
          gap <= gap - 1;
          pixel_valid <= 1'b0;
        end else if (pending_px.size() > 0) begin
          pixel <= pending_px.pop_front();
          pixel_valid <= 1'b1;
          gap <= idle_on ? $urandom_range(0, 12) : 0;
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    int      nxt;
    result_t exp_r;
    nxt = stall_left;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_res.size() == 0) begin
          $error("result transaction with no prediction pending");
          errors++;
        end else begin
          exp_r = expected_res.pop_front();
          if (result.background !== exp_r.background) begin
            $error("background: expected %0b, got %0b", exp_r.background, result.background);
            errors++;
          end
          if (result.frame_done !== exp_r.frame_done) begin
            $error("frame_done: expected %0b, got %0b", exp_r.frame_done, result.frame_done);
            errors++;
          end
          if (result.overflow !== exp_r.overflow) begin
            $error("overflow: expected %0b, got %0b", exp_r.overflow, result.overflow);
            errors++;
          end
        end
        nxt = idle_on ? $urandom_range(0, 12) : 0;
      end
      if (long_req != long_done) begin
        long_done <= long_req;
        nxt = 400;
      end
      if (nxt > 0) begin
        result_stall <= 1'b1;
        stall_left <= nxt - 1;
      end else begin
        result_stall <= 1'b0;
        stall_left <= 0;
      end
    end
  end

  // watchdog: cycles without any transaction
  always @(posedge clk) begin
    if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready) || rst) begin
      quiet <= 0;
    end else if (quiet >= WDOG_LIMIT) begin
      $display("** running_average_background_subtract_unit: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_reg(reg_idx_t idx, int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_HISTORY: hist_len = val & 11'h7FF;
      REG_HUE_THR: hue_thr  = val & 9'h1FF;
      REG_SAT_THR: sat_thr  = val & 13'h1FFF;
      REG_VAL_THR: val_thr  = val & 13'h1FFF;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_px.size() > 0 || pixel_valid || expected_res.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [7:0] jitter(logic [7:0] c, int amt);
    int v;
    v = int'(c) + $urandom_range(0, 2 * amt) - amt;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v;
  endfunction

  task automatic push_frame();
    int     len, kind;
    pixel_t p;
    len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, BASE_LEN);
    for (int i = 0; i < len; i++) begin
      kind = $urandom_range(0, 99);
      p = base_pic[i];
      if (kind < 15) begin
        p.red = $urandom; p.green = $urandom; p.blue = $urandom;
      end else if (kind < 85) begin
        p.red   = jitter(p.red, 6);
        p.green = jitter(p.green, 6);
        p.blue  = jitter(p.blue, 6);
      end
      p.last_in_frame = (i == len - 1);
      pending_px.push_back(p);
    end
  endtask

  initial begin
    int n_items;
    int phase_items;
    base_pic[0]  = '{8'd0,   8'd0,   8'd0,   1'b0};
    base_pic[1]  = '{8'd255, 8'd255, 8'd255, 1'b0};
    base_pic[2]  = '{8'd255, 8'd0,   8'd0,   1'b0};
    base_pic[3]  = '{8'd0,   8'd255, 8'd0,   1'b0};
    base_pic[4]  = '{8'd0,   8'd0,   8'd255, 1'b0};
    base_pic[5]  = '{8'd128, 8'd128, 8'd128, 1'b0};
    base_pic[6]  = '{8'd255, 8'd255, 8'd0,   1'b0};  // red/green tie
    base_pic[7]  = '{8'd0,   8'd255, 8'd255, 1'b0};  // green/blue tie
    base_pic[8]  = '{8'd255, 8'd0,   8'd255, 1'b0};
    base_pic[9]  = '{8'd1,   8'd0,   8'd0,   1'b0};
    base_pic[10] = '{8'd0,   8'd1,   8'd0,   1'b0};
    base_pic[11] = '{8'd0,   8'd0,   8'd1,   1'b0};
    base_pic[12] = '{8'd255, 8'd0,   8'd1,   1'b0};  // hue just below wrap
    base_pic[13] = '{8'd254, 8'd1,   8'd127, 1'b0};
    base_pic[14] = '{8'd127, 8'd254, 8'd1,   1'b0};
    base_pic[15] = '{8'd85,  8'd170, 8'd170, 1'b0};
    for (int i = 16; i < BASE_LEN; i++)
      base_pic[i] = '{8'($urandom), 8'($urandom), 8'($urandom), 1'b0};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // frame zero loads the average; frame one repeats it under reset settings
    for (int f = 0; f < 2; f++)
      for (int i = 0; i < BASE_LEN; i++) begin
        pixel_t p;
        p = base_pic[i];
        p.last_in_frame = (i == BASE_LEN - 1);
        pending_px.push_back(p);
      end
    n_items = 2 * BASE_LEN;

    for (int ph = 0; ph < 9; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          write_reg(REG_HISTORY, 0);    write_reg(REG_HUE_THR, 0);
          write_reg(REG_SAT_THR, 0);    write_reg(REG_VAL_THR, 0);
        end
        1: begin
          write_reg(REG_HISTORY, 2047); write_reg(REG_HUE_THR, 511);
          write_reg(REG_SAT_THR, 8191); write_reg(REG_VAL_THR, 8191);
        end
        2: begin
          write_reg(REG_HISTORY, 1);    write_reg(REG_HUE_THR, 360);
          write_reg(REG_SAT_THR, 4096); write_reg(REG_VAL_THR, 4096);
        end
        3: begin
          write_reg(REG_HISTORY, 1024); write_reg(REG_HUE_THR, 5);
          write_reg(REG_SAT_THR, 200);  write_reg(REG_VAL_THR, 200);
        end
        default: begin
          write_reg(REG_HISTORY, $urandom_range(1, 64));
          write_reg(REG_HUE_THR, $urandom_range(0, 30));
          write_reg(REG_SAT_THR, $urandom_range(0, 800));
          write_reg(REG_VAL_THR, $urandom_range(0, 800));
        end
      endcase
      idle_on = ph[0];
      phase_items = 0;
      while (phase_items < 95) begin
        int before_sz;
        before_sz = pending_px.size();
        push_frame();
        phase_items += pending_px.size() - before_sz;
      end
      n_items += phase_items;
      // receiver holds off while the sender keeps offering pixels
      if (ph == 4) long_req++;
    end

    while (pending_px.size() > 0 || pixel_valid || expected_res.size() > 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && expected_res.size() == 0)
      $display("** running_average_background_subtract_unit: PASSED **");
    else
      $display("** running_average_background_subtract_unit: FAILED **");
    $finish;
  end

endmodule
